>>> src/drms_pkg.sv
// drms_pkg: widths, constants and FSM state type for the decimated RMS envelope.
// No dependencies; used by every module of the block.
package drms_pkg;

    localparam int EMG_W   = 10;
    localparam int ACC_W   = 10;
    localparam int DEC_W   = 16;
    localparam int RMS_W   = 18;
    localparam int RMSC_W  = 19;
    localparam int ACCC_W  = 11;
    localparam int MS_W    = 34;
    localparam int FRAC_W  = 16;
    localparam int SQR_W   = 19;
    localparam int DIVD_W  = SQR_W + FRAC_W;
    localparam int ROOT_W  = MS_W / 2;
    localparam int MID     = 512;

    localparam int SMOOTH_LENGTH_DEF = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_UPD,
        ST_RSTART,
        ST_ROOT,
        ST_EMIT
    } state_t;

endpackage

>>> src/drms_cdiv.sv
// drms_cdiv: bit-serial restoring divider by a constant, one quotient bit per cycle.
// Depends on drms_pkg for its default parameter values.
module drms_cdiv #(
    parameter int DIVISOR = drms_pkg::SMOOTH_LENGTH_DEF,
    parameter int DW      = drms_pkg::DIVD_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int RW = (DIVISOR > 2) ? $clog2(DIVISOR) : 1;
    localparam int CW = $clog2(DW + 1);
    localparam logic [RW:0] M_V = (RW + 1)'(DIVISOR);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] sh_reg;
    logic [RW-1:0] rem_reg;
    logic [RW:0]   trial;
    logic          qbit;
    logic [RW-1:0] rem_next;

    assign trial    = {rem_reg, sh_reg[DW-1]};
    assign qbit     = (trial >= M_V);
    assign rem_next = qbit ? RW'(trial - M_V) : trial[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[DW-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

>>> src/drms_isqrt.sv
// drms_isqrt: bit-serial restoring integer square root, one root bit per cycle.
// Depends on drms_pkg for the radicand and root widths.
module drms_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [drms_pkg::MS_W-1:0]   radicand,
    output logic                        done,
    output logic [drms_pkg::ROOT_W-1:0] root
);
    import drms_pkg::*;

    localparam int REM_W = ROOT_W + 1;
    localparam int CW    = $clog2(ROOT_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [MS_W-1:0]  sh_reg;
    logic [REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W+1:0] part;
    logic [REM_W+1:0] trial;
    logic             ge;
    logic [REM_W-1:0] rem_next;
    logic [ROOT_W-1:0] root_next;

    assign part      = {rem_reg, sh_reg[MS_W-1 -: 2]};
    assign trial     = (REM_W + 2)'({root_reg, 2'b01});
    assign ge        = (part >= trial);
    assign rem_next  = ge ? REM_W'(part - trial) : REM_W'(part);
    assign root_next = {root_reg[ROOT_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg   <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg   <= {sh_reg[MS_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> src/decimated_rms_envelope.sv
// decimated_rms_envelope: leaky mean-square RMS follower with decimated emission.
// One frame at a time: the next frame is taken only once the previous one has finished, output stall included.
// Result registered after the divide, update, root and emit states; 35-step dividers, 17-step root.
// Output register holds a result while the next frame is taken.
// rst_n asynchronous active low: mean square, counters, history and decimation to zero.
// Depends on drms_pkg, drms_cdiv and drms_isqrt.
module decimated_rms_envelope #(
    parameter int SMOOTH_LENGTH = drms_pkg::SMOOTH_LENGTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [drms_pkg::EMG_W-1:0]        emg_sample,
    input  logic [drms_pkg::ACC_W-1:0]        accel_z,
    input  logic                              button_raw,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [drms_pkg::RMS_W-1:0]        rms_level,
    output logic signed [drms_pkg::RMSC_W-1:0] rms_change,
    output logic signed [drms_pkg::ACCC_W-1:0] accel_change,
    output logic                              button_down,
    output logic                              press_event,
    output logic                              release_event,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [drms_pkg::DEC_W-1:0]        cfg_data
);
    import drms_pkg::*;

    localparam logic [MS_W-1:0] MS_MAX = '1;

    state_t state_reg, state_next;

    logic [DEC_W-1:0]  dec_reg;
    logic [DEC_W-1:0]  skip_reg;
    logic [MS_W-1:0]   ms_reg;
    logic [SQR_W-1:0]  sq_reg;
    logic [ACC_W-1:0]  accel_reg;
    logic              braw_reg;
    logic [RMS_W-1:0]  last_rms_reg;
    logic [ACC_W-1:0]  last_accel_reg;
    logic              last_button_reg;
    logic              out_valid_reg;
    logic [RMS_W-1:0]  rms_out_reg;
    logic [RMSC_W-1:0] rmsc_out_reg;
    logic [ACCC_W-1:0] accc_out_reg;
    logic              down_out_reg;
    logic              press_out_reg;
    logic              release_out_reg;

    logic              div_start;
    logic              root_start;
    logic              div_done_a;
    logic              div_done_b;
    logic [DIVD_W-1:0] q_ms;
    logic [DIVD_W-1:0] q_sq;
    logic              root_done;
    logic [ROOT_W-1:0] root;

    logic signed [EMG_W:0] ctr;
    logic [EMG_W-1:0]  mag;
    logic [DIVD_W-1:0] ms_sum;
    logic [MS_W-1:0]   ms_new;
    logic              emit;
    logic              out_free;
    logic              in_accept;
    logic [RMS_W-1:0]  rms_val;
    logic              down;

    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign ctr       = $signed({1'b0, emg_sample}) - $signed((EMG_W + 1)'(MID));
    assign mag       = ctr[EMG_W] ? EMG_W'(-ctr) : EMG_W'(ctr);
    assign ms_sum    = DIVD_W'(ms_reg) - q_ms + q_sq;
    assign ms_new    = (ms_sum > DIVD_W'(MS_MAX)) ? MS_MAX : ms_sum[MS_W-1:0];
    assign emit      = (skip_reg >= dec_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign rms_val   = RMS_W'(root);
    assign down      = ~braw_reg;

    drms_cdiv #(
        .DIVISOR (SMOOTH_LENGTH),
        .DW      (DIVD_W)
    ) u_div_ms (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DIVD_W'(ms_reg)),
        .done     (div_done_a),
        .quotient (q_ms)
    );

    drms_cdiv #(
        .DIVISOR (SMOOTH_LENGTH),
        .DW      (DIVD_W)
    ) u_div_sq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sq_reg, {FRAC_W{1'b0}}}),
        .done     (div_done_b),
        .quotient (q_sq)
    );

    drms_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (ms_reg),
        .done     (root_done),
        .root     (root)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_DIV;
            ST_DIV:    if (div_done_a) state_next = ST_UPD;
            ST_UPD:    state_next = emit ? ST_RSTART : ST_IDLE;
            ST_RSTART: state_next = ST_ROOT;
            ST_ROOT:   if (root_done) state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        div_start  = 1'b0;
        root_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_stall   = 1'b0;
            ST_LOAD:   div_start  = 1'b1;
            ST_RSTART: root_start = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            dec_reg         <= '0;
            skip_reg        <= '0;
            ms_reg          <= '0;
            last_rms_reg    <= '0;
            last_accel_reg  <= '0;
            last_button_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                dec_reg <= cfg_data;
            end
            if (state_reg == ST_UPD)
            begin
                ms_reg   <= ms_new;
                skip_reg <= emit ? '0 : skip_reg + 1'b1;
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg   <= 1'b1;
                last_rms_reg    <= rms_val;
                last_accel_reg  <= accel_reg;
                last_button_reg <= down;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sq_reg    <= SQR_W'(mag * mag);
            accel_reg <= accel_z;
            braw_reg  <= button_raw;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            rms_out_reg     <= rms_val;
            rmsc_out_reg    <= RMSC_W'(rms_val) - RMSC_W'(last_rms_reg);
            accc_out_reg    <= ACCC_W'(accel_reg) - ACCC_W'(last_accel_reg);
            down_out_reg    <= down;
            press_out_reg   <= down && !last_button_reg;
            release_out_reg <= !down && last_button_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign rms_level     = rms_out_reg;
    assign rms_change    = $signed(rmsc_out_reg);
    assign accel_change  = $signed(accc_out_reg);
    assign button_down   = down_out_reg;
    assign press_event   = press_out_reg;
    assign release_event = release_out_reg;

    // transaction accepted only from idle and always enters the load step
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_LOAD)
        else $error("accepted transaction did not start load");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done_a |-> (div_done_b && state_reg == ST_DIV))
        else $error("divider done out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == ST_ROOT)
        else $error("square root done outside root state");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result appeared without emit step");

endmodule

>>> bench/decimated_rms_envelope_test.sv
// decimated_rms_envelope_test: self-checking bench for the decimated RMS envelope follower.
// A queue-fed driver and a clocked monitor compare every result with an in-bench predictor.
// Depends on drms_pkg and decimated_rms_envelope.
module decimated_rms_envelope_test;

    localparam int        QUIET_LIMIT = 4000;
    localparam int        SETTLE      = 100;
    localparam bit [63:0] MS_CEIL     = (64'd1 << drms_pkg::MS_W) - 64'd1;

    typedef struct {
        logic [drms_pkg::EMG_W-1:0] emg;
        logic [drms_pkg::ACC_W-1:0] accel;
        logic                       btn;
    } frame_t;

    typedef struct {
        logic [drms_pkg::RMS_W-1:0]  rms;
        logic [drms_pkg::RMSC_W-1:0] rms_delta;
        logic [drms_pkg::ACCC_W-1:0] accel_delta;
        logic                        down;
        logic                        press;
        logic                        rel;
    } envelope_t;

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 in_valid      = 1'b0;
    logic                                 in_stall;
    logic [drms_pkg::EMG_W-1:0]           emg_sample    = '0;
    logic [drms_pkg::ACC_W-1:0]           accel_z       = '0;
    logic                                 button_raw    = 1'b1;
    logic                                 out_valid;
    logic                                 out_stall     = 1'b0;
    logic [drms_pkg::RMS_W-1:0]           rms_level;
    logic signed [drms_pkg::RMSC_W-1:0]   rms_change;
    logic signed [drms_pkg::ACCC_W-1:0]   accel_change;
    logic                                 button_down;
    logic                                 press_event;
    logic                                 release_event;
    logic                                 cfg_valid     = 1'b0;
    logic                                 cfg_ready;
    logic [drms_pkg::DEC_W-1:0]           cfg_data      = '0;

    frame_t    pending_frames[$];
    envelope_t pending_envelopes[$];

    // predictor state
    bit [63:0]                  ms_acc;
    bit [drms_pkg::DEC_W-1:0]   skip_cnt;
    bit [drms_pkg::DEC_W-1:0]   dec_setting;
    bit [drms_pkg::RMS_W-1:0]   prev_rms;
    bit [drms_pkg::ACC_W-1:0]   prev_accel;
    bit                         prev_down;

    int  snd_idle_pct;
    int  rcv_idle_pct;
    int  mismatches;
    int  frames_in;
    int  results_checked;
    int  sat_emits;
    int  presses;
    int  releases;
    int  cfg_writes;
    bit  btn_level;

    decimated_rms_envelope dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .emg_sample    (emg_sample),
        .accel_z       (accel_z),
        .button_raw    (button_raw),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rms_level     (rms_level),
        .rms_change    (rms_change),
        .accel_change  (accel_change),
        .button_down   (button_down),
        .press_event   (press_event),
        .release_event (release_event),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit [drms_pkg::RMS_W-1:0] floor_root(input bit [63:0] v);
        bit [63:0] r;
        bit [63:0] t;
        r = 0;
        for (int b = drms_pkg::ROOT_W; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r[drms_pkg::RMS_W-1:0];
    endfunction

    task automatic envelope_step(input frame_t f);
        int        x;
        bit [63:0] sq;
        bit [63:0] nxt;
        bit        sat;
        envelope_t e;
        x   = int'(f.emg) - drms_pkg::MID;
        sq  = 64'(x * x) << drms_pkg::FRAC_W;
        nxt = ms_acc - ms_acc / drms_pkg::SMOOTH_LENGTH_DEF
              + sq / drms_pkg::SMOOTH_LENGTH_DEF;
        sat = (nxt > MS_CEIL);
        ms_acc = sat ? MS_CEIL : nxt;
        if (skip_cnt < dec_setting)
        begin
            skip_cnt = skip_cnt + 1'b1;
            return;
        end
        skip_cnt      = '0;
        e.rms         = floor_root(ms_acc);
        e.rms_delta   = drms_pkg::RMSC_W'(e.rms) - drms_pkg::RMSC_W'(prev_rms);
        e.accel_delta = drms_pkg::ACCC_W'(f.accel) - drms_pkg::ACCC_W'(prev_accel);
        e.down        = ~f.btn;
        e.press       = e.down && !prev_down;
        e.rel         = !e.down && prev_down;
        prev_rms      = e.rms;
        prev_accel    = f.accel;
        prev_down     = e.down;
        if (sat)
            sat_emits++;
        if (e.press)
            presses++;
        if (e.rel)
            releases++;
        pending_envelopes.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] expv,
                                   input logic [31:0] gotv);
        mismatches++;
        $display("mismatch on %s at result %0d: expected %0h, got %0h",
                 what, results_checked, expv, gotv);
    endtask

    // sender: holds payload while stalled, otherwise presents the next frame or idles
    always @(posedge clk)
    begin : drive_frames
        frame_t f;
        if (in_valid && !in_stall)
        begin
            f = pending_frames.pop_front();
            envelope_step(f);
            frames_in++;
        end
        if (!(in_valid && in_stall))
        begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= snd_idle_pct)
            begin
                f = pending_frames[0];
                in_valid   <= 1'b1;
                emg_sample <= f.emg;
                accel_z    <= f.accel;
                button_raw <= f.btn;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_results
        envelope_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_envelopes.size() == 0)
                report_mismatch("unexpected transaction", 0, 32'(rms_level));
            else
            begin
                e = pending_envelopes.pop_front();
                if (rms_level !== e.rms)
                    report_mismatch("rms_level", 32'(e.rms), 32'(rms_level));
                if (rms_change !== e.rms_delta)
                    report_mismatch("rms_change", 32'(e.rms_delta),
                                    32'($unsigned(rms_change)));
                if (accel_change !== e.accel_delta)
                    report_mismatch("accel_change", 32'(e.accel_delta),
                                    32'($unsigned(accel_change)));
                if (button_down !== e.down)
                    report_mismatch("button_down", 32'(e.down), 32'(button_down));
                if (press_event !== e.press)
                    report_mismatch("press_event", 32'(e.press), 32'(press_event));
                if (release_event !== e.rel)
                    report_mismatch("release_event", 32'(e.rel), 32'(release_event));
            end
            results_checked++;
        end
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transaction for %0d cycles, %0d results still expected",
                 QUIET_LIMIT, pending_envelopes.size());
        $display("decimated_rms_envelope_test NOT OK");
        $finish;
    end

    task automatic wait_idle();
        while (pending_frames.size() != 0 || in_valid || pending_envelopes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_decimation(input logic [drms_pkg::DEC_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        dec_setting = value;
        cfg_writes++;
    endtask

    task automatic queue_frame(input int emg, input int accel, input bit btn);
        frame_t f;
        f.emg   = drms_pkg::EMG_W'(emg);
        f.accel = drms_pkg::ACC_W'(accel);
        f.btn   = btn;
        pending_frames.push_back(f);
    endtask

    // full_negative pins the sample at the bottom rail to drive the mean square into saturation
    task automatic queue_random_frames(input int count, input bit full_negative);
        int emg;
        int accel;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0:       emg = 0;
                1:       emg = 1023;
                2:       emg = drms_pkg::MID - 4 + $urandom_range(8);
                default: emg = $urandom_range(1023);
            endcase
            if (full_negative)
                emg = 0;
            case ($urandom_range(7))
                0:       accel = 0;
                1:       accel = 1023;
                default: accel = $urandom_range(1023);
            endcase
            if ($urandom_range(99) < 30)
                btn_level = ~btn_level;
            queue_frame(emg, accel, btn_level);
        end
    endtask

    initial
    begin : stimulus
        btn_level    = 1'b1;
        snd_idle_pct = 35;
        rcv_idle_pct = 48;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rails, midscale, bit patterns, press and release edges
        set_decimation(16'd0);
        queue_frame(512, 0, 1'b1);
        queue_frame(0, 1023, 1'b0);
        queue_frame(0, 0, 1'b0);
        queue_frame(1023, 1023, 1'b1);
        queue_frame(511, 512, 1'b1);
        queue_frame(513, 511, 1'b0);
        queue_frame(1, 1, 1'b1);
        queue_frame(1022, 1022, 1'b1);
        queue_frame('h155, 'h2AA, 1'b0);
        queue_frame('h2AA, 'h155, 1'b1);
        queue_frame(512, 0, 1'b1);
        queue_frame(512, 0, 1'b1);

        // count runs up under the widest setting, then the setting drops below it
        set_decimation(16'hFFFF);
        queue_random_frames(6, 1'b0);
        set_decimation(16'd2);
        queue_random_frames(4, 1'b0);

        set_decimation(16'd1);
        queue_random_frames(12, 1'b0);
        set_decimation(16'd5);
        queue_random_frames(24, 1'b0);

        set_decimation(16'd0);
        snd_idle_pct = 48;
        rcv_idle_pct = 35;
        queue_random_frames(12, 1'b0);
        set_decimation(16'd3);
        queue_random_frames(16, 1'b0);

        set_decimation(16'd0);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        queue_random_frames(360, 1'b1);
        queue_random_frames(10, 1'b0);

        wait_idle();
        $display("%0d frames, %0d results checked over %0d decimation writes (0 to 65535)",
                 frames_in, results_checked, cfg_writes);
        $display("%0d presses, %0d releases, %0d emissions at mean-square saturation",
                 presses, releases, sat_emits);
        if (mismatches == 0)
            $display("decimated_rms_envelope_test OK");
        else
            $display("decimated_rms_envelope_test NOT OK");
        $finish;
    end

endmodule
